/* hdl/ooktx_pkg.sv */
// Shared types and timing constants for the OOK remote frame transmitter.
`default_nettype none

package ooktx_pkg;

    // Segment lengths in microsecond ticks
    localparam logic [13:0] LATCH_HIGH_T = 14'd270;
    localparam logic [13:0] LATCH_LOW_T  = 14'd2585;
    localparam logic [13:0] END_HIGH_T   = 14'd275;
    localparam logic [13:0] ONE_HIGH_T   = 14'd275;
    localparam logic [13:0] ONE_LOW_T    = 14'd1240;
    localparam logic [13:0] ZERO_T       = 14'd258;

    localparam int TX_ID_W = 26;
    localparam int REPEAT_W = 4;
    localparam logic [REPEAT_W-1:0] REPEAT_RESET = 4'd5;

    // Register index decoded from the byte address
    localparam logic REG_TX_ID  = 1'b0;
    localparam logic REG_REPEAT = 1'b1;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LATCH_HIGH = 3'd1,
        PH_LATCH_LOW  = 3'd2,
        PH_SYM_HIGH   = 3'd3,
        PH_SYM_LOW    = 3'd4,
        PH_END_HIGH   = 3'd5,
        PH_GAP        = 3'd6
    } phase_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       switch_on;
        logic [3:0] unit_number;
        logic [3:0] dim_level;
    } item_t;

    typedef struct packed {
        logic tx_level;
        logic busy_res;
    } result_t;

endpackage

`default_nettype wire

/* hdl/ook_remote_frame_transmitter_core.sv */
// Top level of the OOK remote frame transmitter: register port and queue wiring.
//
// Usage:
//   Input channel (push/full): each beat is either a one-microsecond tick
//   (command 0) or a start request (command 1) carrying switch_on,
//   unit_number and dim_level. A start while a transmission is running is
//   dropped. Every input beat yields exactly one result beat.
//   Result channel (empty/pop): tx_level is the radio pin level for that
//   tick (or the level now driven, for a start) and busy_res flags that a
//   frame or inter-frame gap is in progress.
//   Registers (APB, pready tied high): transmitter_id at 0x0, repeat_count
//   at 0x4. Write them only while no beat is in flight.
//   Throughput: one beat per cycle while the result queue has room; the frame
//   sequencer resolves each beat combinationally against a 14-bit segment timer.
//   Path: an accepted push enters the input queue; the sequencer resolves the
//   beat at the head of that queue and writes it into the result queue, whereupon
//   empty goes low and the result can be popped.
//   Reset: queues empty, sequencer idle with the pin low, transmitter_id 0,
//   repeat_count 5.
//   Stalls: if pop is held low the result queue fills, the sequencer holds,
//   and full rises once the two-entry input queue is occupied; no beat is
//   lost, and pulse timing counts ticks, not cycles.
`default_nettype none

module ook_remote_frame_transmitter_core
#(
    parameter int ID_BITS   = 26,
    parameter int GAP_TICKS = 10000
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command channel
    input  wire logic        push,
    output logic             full,
    input  wire logic        command,
    input  wire logic        switch_on,
    input  wire logic [3:0]  unit_number,
    input  wire logic [3:0]  dim_level,
    // result channel
    output logic             empty,
    input  wire logic        pop,
    output logic             tx_level,
    output logic             busy_res,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [ooktx_pkg::TX_ID_W-1:0]  tx_id_reg;
    logic [ooktx_pkg::REPEAT_W-1:0] repeat_reg;
    logic                           cfg_write;

    ooktx_pkg::item_t   item;
    logic               item_valid;
    logic               item_take;
    ooktx_pkg::result_t res;
    logic               res_push;
    logic               res_room;

    // Register port: zero wait states, register picked by address bit 2
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            ooktx_pkg::REG_TX_ID:  prdata = {6'd0, tx_id_reg};
            ooktx_pkg::REG_REPEAT: prdata = {28'd0, repeat_reg};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_id_reg  <= '0;
            repeat_reg <= ooktx_pkg::REPEAT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                ooktx_pkg::REG_TX_ID:  tx_id_reg  <= pwdata[ooktx_pkg::TX_ID_W-1:0];
                ooktx_pkg::REG_REPEAT: repeat_reg <= pwdata[ooktx_pkg::REPEAT_W-1:0];
                default:               tx_id_reg  <= tx_id_reg;
            endcase
        end
    end

    // Front: accept and classify command beats
    ooktx_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .switch_on   (switch_on),
        .unit_number (unit_number),
        .dim_level   (dim_level),
        .item        (item),
        .item_valid  (item_valid),
        .item_take   (item_take)
    );

    // Back: advance the frame sequencer one beat per cycle while the result queue has room
    ooktx_back
    #(
        .ID_BITS   (ID_BITS),
        .GAP_TICKS (GAP_TICKS)
    )
    u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .item_valid     (item_valid),
        .item_take      (item_take),
        .res_room       (res_room),
        .res            (res),
        .res_push       (res_push),
        .transmitter_id (tx_id_reg),
        .repeat_count   (repeat_reg)
    );

    // Result queue: hold finished beats until popped
    ooktx_res_q u_res_q
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .res_push (res_push),
        .res_room (res_room),
        .empty    (empty),
        .pop      (pop),
        .tx_level (tx_level),
        .busy_res (busy_res)
    );

endmodule

`default_nettype wire

/* hdl/ooktx_front.sv */
// Front end: two-entry input queue that takes and classifies command beats.
`default_nettype none

module ooktx_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic            command,
    input  wire logic            switch_on,
    input  wire logic [3:0]      unit_number,
    input  wire logic [3:0]      dim_level,
    output ooktx_pkg::item_t     item,
    output logic                 item_valid,
    input  wire logic            item_take
);

    ooktx_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;
    ooktx_pkg::item_t in_item;

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign do_push    = push && !full;
    assign do_pop     = item_take && item_valid;

    // Classify the incoming beat
    always_comb
    begin
        in_item.cmd         = command ? ooktx_pkg::CMD_START : ooktx_pkg::CMD_TICK;
        in_item.switch_on   = switch_on;
        in_item.unit_number = unit_number;
        in_item.dim_level   = dim_level;
    end

    assign item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* hdl/ooktx_back.sv */
// Back end: frame sequencer that runs one command beat per cycle while res_room is high.
`default_nettype none

module ooktx_back
#(
    parameter int ID_BITS   = 26,
    parameter int GAP_TICKS = 10000
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ooktx_pkg::item_t                item,
    input  wire logic                            item_valid,
    output logic                                 item_take,
    input  wire logic                            res_room,
    output ooktx_pkg::result_t                   res,
    output logic                                 res_push,
    input  wire logic [ooktx_pkg::TX_ID_W-1:0]   transmitter_id,
    input  wire logic [ooktx_pkg::REPEAT_W-1:0]  repeat_count
);

    localparam int FW  = ID_BITS + 10;
    localparam int FIW = $clog2(FW);
    localparam logic [6:0]  FW_LIM     = 7'(FW);
    localparam logic [6:0]  DIM_BIT    = 7'(ID_BITS + 1);
    localparam logic [7:0]  BASE_TOTAL = 8'(2 * (ID_BITS + 6));
    localparam logic [13:0] GAP_LEN    = 14'(GAP_TICKS);

    ooktx_pkg::phase_t phase_reg;
    ooktx_pkg::phase_t phase_next;
    logic [13:0] timer_reg;
    logic [13:0] timer_next;
    logic [7:0]  sym_reg;
    logic [7:0]  sym_next;
    logic [3:0]  rep_reg;
    logic [3:0]  rep_next;
    logic        on_reg;
    logic        on_next;
    logic [3:0]  unit_reg;
    logic [3:0]  unit_next;
    logic [3:0]  level_reg;
    logic [3:0]  level_next;
    logic        pin_reg;
    logic        pin_next;

    logic        fire;
    logic        is_start;
    logic [31:0] tid_ext;
    logic [FW-1:0] frame_bits;
    logic [FW-1:0] frame_rev;
    logic [6:0]  bit_idx;
    logic        data_bit;
    logic        dimming;
    logic        sym_val;
    logic [7:0]  sym_total;
    logic [7:0]  sym_inc;
    logic [13:0] timer_inc;
    logic [13:0] seg_len;

    assign fire     = item_valid && res_room;
    assign is_start = (item.cmd == ooktx_pkg::CMD_START);

    // Frame payload, first bit sent at index zero of frame_rev
    assign tid_ext    = {6'd0, transmitter_id};
    assign frame_bits = {tid_ext[ID_BITS-1:0], 1'b0, on_reg, unit_reg, level_reg};

    always_comb
    begin
        for (int j = 0; j < FW; j++)
        begin
            frame_rev[j] = frame_bits[FW-1-j];
        end
    end

    assign dimming   = (level_reg != 4'd0);
    assign bit_idx   = sym_reg[7:1];
    assign data_bit  = (bit_idx < FW_LIM) ? frame_rev[bit_idx[FIW-1:0]] : 1'b0;
    // While dimming the on/off bit goes out as two zero symbols
    assign sym_val   = (dimming && bit_idx == DIM_BIT) ? 1'b0 : (data_bit ^ sym_reg[0]);
    assign sym_total = BASE_TOTAL + (dimming ? 8'd8 : 8'd0);
    assign sym_inc   = sym_reg + 8'd1;
    assign timer_inc = timer_reg + 14'd1;

    always_comb
    begin
        case (phase_reg)
            ooktx_pkg::PH_LATCH_HIGH: seg_len = ooktx_pkg::LATCH_HIGH_T;
            ooktx_pkg::PH_LATCH_LOW:  seg_len = ooktx_pkg::LATCH_LOW_T;
            ooktx_pkg::PH_SYM_HIGH:   seg_len = sym_val ? ooktx_pkg::ONE_HIGH_T
                                                        : ooktx_pkg::ZERO_T;
            ooktx_pkg::PH_SYM_LOW:    seg_len = sym_val ? ooktx_pkg::ONE_LOW_T
                                                        : ooktx_pkg::ZERO_T;
            ooktx_pkg::PH_END_HIGH:   seg_len = ooktx_pkg::END_HIGH_T;
            ooktx_pkg::PH_GAP:        seg_len = GAP_LEN;
            default:                  seg_len = 14'd1;
        endcase
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        sym_next   = sym_reg;
        rep_next   = rep_reg;
        on_next    = on_reg;
        unit_next  = unit_reg;
        level_next = level_reg;
        pin_next   = pin_reg;
        if (fire)
        begin
            if (is_start)
            begin
                if (phase_reg == ooktx_pkg::PH_IDLE && repeat_count != 4'd0)
                begin
                    on_next    = item.switch_on;
                    unit_next  = item.unit_number;
                    level_next = item.dim_level;
                    rep_next   = repeat_count;
                    sym_next   = 8'd0;
                    phase_next = ooktx_pkg::PH_LATCH_HIGH;
                    pin_next   = 1'b1;
                    timer_next = 14'd0;
                end
            end
            else if (phase_reg != ooktx_pkg::PH_IDLE)
            begin
                timer_next = timer_inc;
                if (timer_inc >= seg_len)
                begin
                    timer_next = 14'd0;
                    case (phase_reg)
                        ooktx_pkg::PH_LATCH_HIGH:
                        begin
                            phase_next = ooktx_pkg::PH_LATCH_LOW;
                            pin_next   = 1'b0;
                        end
                        ooktx_pkg::PH_LATCH_LOW:
                        begin
                            sym_next   = 8'd0;
                            phase_next = ooktx_pkg::PH_SYM_HIGH;
                            pin_next   = 1'b1;
                        end
                        ooktx_pkg::PH_SYM_HIGH:
                        begin
                            phase_next = ooktx_pkg::PH_SYM_LOW;
                            pin_next   = 1'b0;
                        end
                        ooktx_pkg::PH_SYM_LOW:
                        begin
                            sym_next   = sym_inc;
                            pin_next   = 1'b1;
                            phase_next = (sym_inc >= sym_total) ? ooktx_pkg::PH_END_HIGH
                                                                : ooktx_pkg::PH_SYM_HIGH;
                        end
                        ooktx_pkg::PH_END_HIGH:
                        begin
                            phase_next = ooktx_pkg::PH_GAP;
                            pin_next   = 1'b0;
                        end
                        ooktx_pkg::PH_GAP:
                        begin
                            rep_next = rep_reg - 4'd1;
                            sym_next = 8'd0;
                            if (rep_reg != 4'd1)
                            begin
                                phase_next = ooktx_pkg::PH_LATCH_HIGH;
                                pin_next   = 1'b1;
                            end
                            else
                            begin
                                phase_next = ooktx_pkg::PH_IDLE;
                                pin_next   = 1'b0;
                            end
                        end
                        default:
                        begin
                            phase_next = ooktx_pkg::PH_IDLE;
                            pin_next   = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    // Outputs: a start reports the state it enters, a tick the level it spans
    always_comb
    begin
        item_take = fire;
        res_push  = fire;
        if (is_start)
        begin
            res.tx_level = pin_next;
            res.busy_res = (phase_next != ooktx_pkg::PH_IDLE);
        end
        else
        begin
            res.tx_level = pin_reg;
            res.busy_res = (phase_reg != ooktx_pkg::PH_IDLE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ooktx_pkg::PH_IDLE;
            timer_reg <= 14'd0;
            sym_reg   <= 8'd0;
            rep_reg   <= 4'd0;
            on_reg    <= 1'b0;
            unit_reg  <= 4'd0;
            level_reg <= 4'd0;
            pin_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            sym_reg   <= sym_next;
            rep_reg   <= rep_next;
            on_reg    <= on_next;
            unit_reg  <= unit_next;
            level_reg <= level_next;
            pin_reg   <= pin_next;
        end
    end

    a_idle_pin_low: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ooktx_pkg::PH_IDLE) |-> !pin_reg)
        else $error("pin driven high while idle");

    a_busy_has_repeats: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != ooktx_pkg::PH_IDLE) |-> (rep_reg != 4'd0))
        else $error("frame running with no repeats left");

    a_symbol_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ooktx_pkg::PH_SYM_HIGH || phase_reg == ooktx_pkg::PH_SYM_LOW)
        |-> (sym_reg < sym_total))
        else $error("symbol index past end of frame");

endmodule

`default_nettype wire

/* hdl/ooktx_res_q.sv */
// Two-entry result queue that parts the sequencer from the result consumer.
`default_nettype none

module ooktx_res_q
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ooktx_pkg::result_t res,
    input  wire logic               res_push,
    output logic                    res_room,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    tx_level,
    output logic                    busy_res
);

    ooktx_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign empty    = (count_reg == 2'd0);
    assign res_room = (count_reg != 2'd2);
    assign do_push  = res_push && res_room;
    assign do_pop   = pop && !empty;
    assign tx_level = entry_reg[rd_ptr_reg].tx_level;
    assign busy_res = entry_reg[rd_ptr_reg].busy_res;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

`default_nettype wire
